[rtl/image_resize_nearest_or_box_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the image scaler
// Shared concurrent assertion forms, one clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_RESIZE_NEAREST_OR_BOX_TOP_ASSERT_SVH
`define IMAGE_RESIZE_NEAREST_OR_BOX_TOP_ASSERT_SVH

// Same-cycle implication.
`define IRS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IRS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/imgrsz_pkg.sv]
// ----------------------------------------------------------------------------
// Image scaler package
// Beat types, register indexes and fixed widths of the image scaler.
// ----------------------------------------------------------------------------
package imgrsz_pkg;

  localparam int DEF_MAX_SRC_DIM = 256;
  localparam int DEF_MAX_DST_DIM = 1024;

  localparam int COORD_W    = 10;
  localparam int PIX_W      = 8;
  localparam int SRC_DIM_W  = 9;
  localparam int DST_DIM_W  = 11;
  localparam int STEP_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COORD_W + STEP_W;
  localparam int INT_W      = PROD_W - FRAC_W;
  localparam int CMP_W      = 14;
  localparam int SUM_W      = PIX_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic MODE_NEAREST = 1'b0;
  localparam logic MODE_BOX     = 1'b1;

  localparam logic [SRC_DIM_W-1:0] RST_SRC_DIM = SRC_DIM_W'(256);
  localparam logic [DST_DIM_W-1:0] RST_DST_DIM = DST_DIM_W'(256);
  localparam logic [STEP_W-1:0]    RST_STEP    = STEP_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_MODE = 3'd0,
    CFG_SRC_WIDTH  = 3'd1,
    CFG_SRC_HEIGHT = 3'd2,
    CFG_DST_WIDTH  = 3'd3,
    CFG_DST_HEIGHT = 3'd4,
    CFG_ROW_STEP   = 3'd5,
    CFG_COL_STEP   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } out_item_t;

endpackage

[rtl/image_resize_nearest_or_box_top.sv]
// ----------------------------------------------------------------------------
// Image scaler, nearest neighbor or two-by-two box average
// Load beats write 8-bit gray source pixels into an on-chip image store;
// query beats name one destination pixel and return one scaled value. The
// block takes one beat per cycle while in_stall is low, loads and queries
// freely mixed. A query passes four pipeline registers: input with step
// multiply, coordinate clamp with store read, sample select and averaging,
// and the output register, in that order. The store is split into four
// banks by row and column parity, each with one port, so a whole two-by-two
// block is read in the same cycle; that bank port is what holds the rate at
// one beat per cycle when nothing stalls. Store entries hold no value until
// a load writes them, and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "image_resize_nearest_or_box_top_assert.svh"

module image_resize_nearest_or_box_top
  import imgrsz_pkg::*;
#(
  parameter int MAX_SRC_DIM = DEF_MAX_SRC_DIM,
  parameter int MAX_DST_DIM = DEF_MAX_DST_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW         = $clog2(MAX_SRC_DIM);
  localparam int BKW        = (AW > 1) ? AW - 1 : 1;
  localparam int BANK_AW    = 2 * BKW;
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  // Configuration registers.
  logic                 scale_mode_r;
  logic [SRC_DIM_W-1:0] src_width_r;
  logic [SRC_DIM_W-1:0] src_height_r;
  logic [DST_DIM_W-1:0] dst_width_r;
  logic [DST_DIM_W-1:0] dst_height_r;
  logic [STEP_W-1:0]    row_step_r;
  logic [STEP_W-1:0]    col_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r <= MODE_NEAREST;
      src_width_r  <= RST_SRC_DIM;
      src_height_r <= RST_SRC_DIM;
      dst_width_r  <= RST_DST_DIM;
      dst_height_r <= RST_DST_DIM;
      row_step_r   <= RST_STEP;
      col_step_r   <= RST_STEP;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SCALE_MODE: scale_mode_r <= cfg_wdata[0];
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SRC_DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[SRC_DIM_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata[DST_DIM_W-1:0];
        CFG_DST_HEIGHT: dst_height_r <= cfg_wdata[DST_DIM_W-1:0];
        CFG_ROW_STEP:   row_step_r   <= cfg_wdata[STEP_W-1:0];
        CFG_COL_STEP:   col_step_r   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes and last source row and column.
  logic [CMP_W-1:0] src_h_eff;
  logic [CMP_W-1:0] src_w_eff;
  logic [CMP_W-1:0] dst_h_eff;
  logic [CMP_W-1:0] dst_w_eff;
  logic [AW-1:0]    last_r;
  logic [AW-1:0]    last_c;

  always_comb begin
    src_h_eff = CMP_W'(src_height_r);
    if (src_h_eff == CMP_W'(0)) begin
      src_h_eff = CMP_W'(1);
    end else if (src_h_eff > CMP_W'(MAX_SRC_DIM)) begin
      src_h_eff = CMP_W'(MAX_SRC_DIM);
    end
    src_w_eff = CMP_W'(src_width_r);
    if (src_w_eff == CMP_W'(0)) begin
      src_w_eff = CMP_W'(1);
    end else if (src_w_eff > CMP_W'(MAX_SRC_DIM)) begin
      src_w_eff = CMP_W'(MAX_SRC_DIM);
    end
    dst_h_eff = CMP_W'(dst_height_r);
    if (dst_h_eff > CMP_W'(MAX_DST_DIM)) begin
      dst_h_eff = CMP_W'(MAX_DST_DIM);
    end
    dst_w_eff = CMP_W'(dst_width_r);
    if (dst_w_eff > CMP_W'(MAX_DST_DIM)) begin
      dst_w_eff = CMP_W'(MAX_DST_DIM);
    end
    last_r = AW'(src_h_eff - CMP_W'(1));
    last_c = AW'(src_w_eff - CMP_W'(1));
  end

  // Pipeline handshake.
  logic in_accept;
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic s3_valid_r, s3_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic s3_adv;
  logic s3_free;
  logic s2_is_query;
  logic s2_go;
  logic s2_free;
  logic s1_go;

  assign out_free    = !out_valid_r || !out_stall;
  assign s3_adv      = s3_valid_r && out_free;
  assign s3_free     = !s3_valid_r || out_free;
  assign s2_go       = s2_valid_r && (!s2_is_query || s3_free);
  assign s2_free     = !s2_valid_r || s2_go;
  assign s1_go       = s1_valid_r && s2_free;
  assign in_stall    = s1_valid_r && !s2_free;
  assign in_accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s1_go) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_go) begin
      s2_valid_nxt = 1'b0;
    end
    s3_valid_nxt = s3_valid_r;
    if (s2_go && s2_is_query) begin
      s3_valid_nxt = 1'b1;
    end else if (s3_adv) begin
      s3_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s3_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1: input register and step multiplies.
  in_item_t          s1_item_r;
  logic [PROD_W-1:0] s1_rprod;
  logic [PROD_W-1:0] s1_cprod;
  logic              s1_redge;
  logic              s1_cedge;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
  end

  assign s1_rprod = PROD_W'(s1_item_r.row) * PROD_W'(row_step_r);
  assign s1_cprod = PROD_W'(s1_item_r.col) * PROD_W'(col_step_r);
  assign s1_redge = (CMP_W'(s1_item_r.row) + CMP_W'(1)) >= dst_h_eff;
  assign s1_cedge = (CMP_W'(s1_item_r.col) + CMP_W'(1)) >= dst_w_eff;

  // Stage 2: coordinate clamp and store access.
  logic               s2_req_r;
  logic [COORD_W-1:0] s2_row_r;
  logic [COORD_W-1:0] s2_col_r;
  logic [PIX_W-1:0]   s2_pix_r;
  logic [PROD_W-1:0]  s2_rprod_r;
  logic [PROD_W-1:0]  s2_cprod_r;
  logic               s2_redge_r;
  logic               s2_cedge_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_req_r   <= s1_item_r.req_type;
      s2_row_r   <= s1_item_r.row;
      s2_col_r   <= s1_item_r.col;
      s2_pix_r   <= s1_item_r.pixel_in;
      s2_rprod_r <= s1_rprod;
      s2_cprod_r <= s1_cprod;
      s2_redge_r <= s1_redge;
      s2_cedge_r <= s1_cedge;
    end
  end

  logic [INT_W-1:0] s2_rc;
  logic [INT_W-1:0] s2_cc;
  logic [AW-1:0]    r0;
  logic [AW-1:0]    r1;
  logic [AW-1:0]    c0;
  logic [AW-1:0]    c1;
  logic [AW-1:0]    ld_r;
  logic [AW-1:0]    ld_c;
  logic             ld_ok;

  assign s2_is_query = (s2_req_r == REQ_QUERY);
  assign s2_rc = s2_rprod_r[PROD_W-1:FRAC_W];
  assign s2_cc = s2_cprod_r[PROD_W-1:FRAC_W];

  always_comb begin
    r0 = (s2_rc > INT_W'(last_r)) ? last_r : AW'(s2_rc);
    c0 = (s2_cc > INT_W'(last_c)) ? last_c : AW'(s2_cc);
    if (s2_redge_r) begin
      r1 = r0;
    end else begin
      r1 = (r0 < last_r) ? r0 + AW'(1) : last_r;
    end
    if (s2_cedge_r) begin
      c1 = c0;
    end else begin
      c1 = (c0 < last_c) ? c0 + AW'(1) : last_c;
    end
  end

  assign ld_ok = (CMP_W'(s2_row_r) < CMP_W'(MAX_SRC_DIM)) &&
                 (CMP_W'(s2_col_r) < CMP_W'(MAX_SRC_DIM));
  assign ld_r  = AW'(s2_row_r);
  assign ld_c  = AW'(s2_col_r);

  // Four parity banks; bank index is {row parity, column parity}.
  logic [3:0]         bank_we;
  logic [3:0]         bank_re;
  logic [PIX_W-1:0]   rd_r [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = 1'(b / 2);
    localparam logic CP = 1'(b % 2);

    logic [AW-1:0]      row_sel;
    logic [AW-1:0]      col_sel;
    logic [BANK_AW-1:0] addr;
    logic [PIX_W-1:0]   bank_mem [BANK_DEPTH];

    always_comb begin
      if (s2_is_query) begin
        row_sel = (r0[0] == RP) ? r0 : r1;
        col_sel = (c0[0] == CP) ? c0 : c1;
      end else begin
        row_sel = ld_r;
        col_sel = ld_c;
      end
      addr = {BKW'(row_sel >> 1), BKW'(col_sel >> 1)};
    end

    assign bank_we[b] = s2_valid_r && !s2_is_query && ld_ok &&
                        (ld_r[0] == RP) && (ld_c[0] == CP);
    assign bank_re[b] = s2_go && s2_is_query;

    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        bank_mem[addr] <= s2_pix_r;
      end
      if (bank_re[b]) begin
        rd_r[b] <= bank_mem[addr];
      end
    end
  end

  // Stage 3: select the four samples; box mode averages them, nearest takes v00.
  logic [COORD_W-1:0] s3_row_r;
  logic [COORD_W-1:0] s3_col_r;
  logic               s3_r0p_r;
  logic               s3_r1p_r;
  logic               s3_c0p_r;
  logic               s3_c1p_r;

  always_ff @(posedge clk) begin
    if (s2_go && s2_is_query) begin
      s3_row_r <= s2_row_r;
      s3_col_r <= s2_col_r;
      s3_r0p_r <= r0[0];
      s3_r1p_r <= r1[0];
      s3_c0p_r <= c0[0];
      s3_c1p_r <= c1[0];
    end
  end

  logic [PIX_W-1:0] v00;
  logic [PIX_W-1:0] v10;
  logic [PIX_W-1:0] v01;
  logic [PIX_W-1:0] v11;
  logic [SUM_W-1:0] box_sum;
  logic [PIX_W-1:0] s3_pix;

  assign v00     = rd_r[{s3_r0p_r, s3_c0p_r}];
  assign v10     = rd_r[{s3_r1p_r, s3_c0p_r}];
  assign v01     = rd_r[{s3_r0p_r, s3_c1p_r}];
  assign v11     = rd_r[{s3_r1p_r, s3_c1p_r}];
  assign box_sum = SUM_W'(v00) + SUM_W'(v10) + SUM_W'(v01) + SUM_W'(v11);
  assign s3_pix  = (scale_mode_r == MODE_BOX) ? box_sum[SUM_W-1:2] : v00;

  // Output register.
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      out_data_r.pixel_out <= s3_pix;
      out_data_r.out_row   <= s3_row_r;
      out_data_r.out_col   <= s3_col_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IRS_ASSERT_SAME(a_bank_rw_excl, clk, rst_n, |bank_we, !(|bank_re), "store write and read in one cycle")
  `IRS_ASSERT_SAME(a_row_pair, clk, rst_n, s2_valid_r && s2_is_query, (r1 == r0) || (r1 == r0 + AW'(1)), "second row not adjacent")
  `IRS_ASSERT_NEXT(a_query_moves, clk, rst_n, s2_go && s2_is_query, s3_valid_r, "query lost after store read")
  `IRS_ASSERT_NEXT(a_load_no_result, clk, rst_n, s2_valid_r && !s2_is_query && !(s3_valid_r && !s3_adv), !s3_valid_r, "load beat reached averaging stage")
  `IRS_ASSERT_NEXT(a_rd_hold, clk, rst_n, s3_valid_r && !s3_adv, {rd_r[0], rd_r[1], rd_r[2], rd_r[3]} === $past({rd_r[0], rd_r[1], rd_r[2], rd_r[3]}), "read data changed under a held beat")

endmodule
